>>> design/awsp_pkg.sv
// Shared types and record codes for the animation word stream parser.
// No dependencies; imported by the core and its checker.
package awsp_pkg;

  // Record kinds carried in record_kind
  localparam logic [3:0] KIND_HEADER  = 4'd0;
  localparam logic [3:0] KIND_POSE    = 4'd1;
  localparam logic [3:0] KIND_KEYFR   = 4'd2;
  localparam logic [3:0] KIND_ENTRY   = 4'd3;
  localparam logic [3:0] KIND_AXIS    = 4'd4;
  localparam logic [3:0] KIND_LOOP_ST = 4'd5;
  localparam logic [3:0] KIND_LOOP_END = 4'd6;
  localparam logic [3:0] KIND_TEXTURE = 4'd7;
  localparam logic [3:0] KIND_SOUND   = 4'd8;
  localparam logic [3:0] KIND_END     = 4'd9;
  localparam logic [3:0] KIND_ERROR   = 4'd10;

  // Instruction opcodes, word bits 15..12
  localparam logic [3:0] OP_KEYFRAME   = 4'd0;
  localparam logic [3:0] OP_LOOP_START = 4'd1;
  localparam logic [3:0] OP_LOOP_END   = 4'd2;
  localparam logic [3:0] OP_TEXTURE    = 4'd3;
  localparam logic [3:0] OP_SOUND      = 4'd4;

  // First pose component without scale (rot x)
  localparam logic [3:0] COMP_ROT_X = 4'd3;
  localparam logic [3:0] COMP_LAST  = 4'd8;

  typedef struct packed {
    logic [15:0] data_word;
    logic        stream_end;
  } awsp_in_t;

  typedef struct packed {
    logic [3:0]         record_kind;
    logic [14:0]        count_or_time;
    logic               scale_present;
    logic [5:0]         node_index;
    logic [3:0]         component;
    logic signed [15:0] signed_value;
    logic [15:0]        aux_word;
    logic [47:0]        texture_rect;
  } awsp_out_t;

endpackage

>>> design/animation_word_stream_parser_core.sv
// Animation word stream parser core: input word register, parse logic, result register.
// Depends on awsp_pkg.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one 16-bit animation word per
//   handshake, with stream_end marking the last word of the buffer. Output channel
//   out_valid/out_ready/out_data carries parsed records (header, pose value,
//   keyframe, entry, axis value, loop start/end, texture, sound, end, error).
//   A word yields zero or one record; entry, loop-end, texture and sound opcodes
//   and the first two texture words only update parser state.
//   cfg_wr_en/cfg_wr_data write bone_count (reset value 1); write it only while idle.
// Timing:
//   One word per clock sustained while the receiver keeps out_ready high. An accepted
//   word is held in the input register and parsed from there; its record goes
//   into the result register, which drives out_data.
//   The input register lets one more word in while a record waits on a stalled
//   receiver; after that in_ready drops until out_ready returns.
// Reset:
//   rst (synchronous) empties both registers, returns the parser to expecting a
//   header and sets bone_count to 1.
module animation_word_stream_parser_core
  import awsp_pkg::*;
#(
  parameter int MAX_BONES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  awsp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output awsp_out_t out_data,
  input  logic      cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  localparam logic [6:0] MaxBones = 7'(MAX_BONES);

  typedef enum logic [2:0] {
    PH_HEADER, PH_POSE, PH_INSTR, PH_ENTRY_SCALE,
    PH_AXIS, PH_LOOP_END, PH_TEXTURE, PH_SOUND
  } phase_t;

  logic [6:0]  bone_count;
  logic        s1_valid;
  awsp_in_t    s1_data;
  logic        s2_free;
  logic        s1_go;

  phase_t      phase, phase_next;
  logic        scale_flag, scale_flag_next;
  logic [6:0]  bone_counter, bone_counter_next;
  logic [3:0]  comp_cnt, comp_cnt_next;
  logic [8:0]  axis_mask, axis_mask_next;
  logic        in_keyframe, in_keyframe_next;
  logic [11:0] held_tc, held_tc_next;
  logic [31:0] tex_words, tex_words_next;
  logic [1:0]  tex_cnt, tex_cnt_next;
  logic [5:0]  held_node, held_node_next;

  logic        res_valid;
  awsp_out_t   res;
  logic [6:0]  eff_bones;
  logic [15:0] w;
  logic [11:0] tc;
  logic [3:0]  axis_bit;
  logic [6:0]  bone_inc;

  assign s2_free  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_free;
  assign s1_go    = s1_valid && s2_free;

  assign eff_bones = (bone_count > MaxBones) ? MaxBones : bone_count;
  assign w  = s1_data.data_word;
  assign tc = w[11:0];
  assign bone_inc = bone_counter + 7'd1;

  // highest set bit among 8..1, else bit 0
  always_comb begin
    axis_bit = 4'd0;
    for (int i = 1; i <= 8; i++) begin
      if (axis_mask[i]) axis_bit = 4'(i);
    end
  end

  always_comb begin
    phase_next        = phase;
    scale_flag_next   = scale_flag;
    bone_counter_next = bone_counter;
    comp_cnt_next     = comp_cnt;
    axis_mask_next    = axis_mask;
    in_keyframe_next  = in_keyframe;
    held_tc_next      = held_tc;
    tex_words_next    = tex_words;
    tex_cnt_next      = tex_cnt;
    held_node_next    = held_node;
    res_valid         = 1'b0;
    res               = '0;

    if (s1_data.stream_end && !(phase == PH_INSTR && w == 16'h0000)) begin
      // premature end: error record and restart
      res_valid         = 1'b1;
      res.record_kind   = KIND_ERROR;
      phase_next        = PH_HEADER;
      bone_counter_next = 7'd1;
      comp_cnt_next     = 4'd0;
      axis_mask_next    = '0;
      in_keyframe_next  = 1'b0;
      tex_cnt_next      = '0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          scale_flag_next   = w[15];
          res_valid         = 1'b1;
          res.record_kind   = KIND_HEADER;
          res.count_or_time = w[14:0];
          res.scale_present = w[15];
          bone_counter_next = 7'd1;
          comp_cnt_next     = w[15] ? 4'd0 : COMP_ROT_X;
          in_keyframe_next  = 1'b0;
          phase_next        = (eff_bones > 7'd1) ? PH_POSE : PH_INSTR;
        end
        PH_POSE: begin
          res_valid        = 1'b1;
          res.record_kind  = KIND_POSE;
          res.node_index   = bone_counter[5:0];
          res.component    = comp_cnt;
          res.signed_value = w;
          if (comp_cnt >= COMP_LAST) begin
            bone_counter_next = bone_inc;
            comp_cnt_next     = scale_flag ? 4'd0 : COMP_ROT_X;
            if (bone_inc >= eff_bones) phase_next = PH_INSTR;
          end else begin
            comp_cnt_next = comp_cnt + 4'd1;
          end
        end
        PH_INSTR: begin
          if (w == 16'h0000) begin
            res_valid         = 1'b1;
            res.record_kind   = KIND_END;
            phase_next        = PH_HEADER;
            bone_counter_next = 7'd1;
            comp_cnt_next     = 4'd0;
            axis_mask_next    = '0;
            in_keyframe_next  = 1'b0;
            tex_cnt_next      = '0;
          end else if (in_keyframe && w[15]) begin
            held_node_next = w[5:0];
            axis_mask_next = w[14:6];
            phase_next     = PH_ENTRY_SCALE;
          end else begin
            in_keyframe_next = 1'b0;
            unique case (w[15:12])
              OP_KEYFRAME: begin
                held_tc_next      = tc;
                in_keyframe_next  = 1'b1;
                res_valid         = 1'b1;
                res.record_kind   = KIND_KEYFR;
                res.count_or_time = {3'b000, tc};
              end
              OP_LOOP_START: begin
                res_valid         = 1'b1;
                res.record_kind   = KIND_LOOP_ST;
                res.count_or_time = {7'd0, w[7:0]};
              end
              OP_LOOP_END: begin
                held_tc_next = tc;
                phase_next   = PH_LOOP_END;
              end
              OP_TEXTURE: begin
                held_tc_next   = tc;
                tex_cnt_next   = '0;
                tex_words_next = '0;
                phase_next     = PH_TEXTURE;
              end
              OP_SOUND: begin
                held_tc_next = tc;
                phase_next   = PH_SOUND;
              end
              default: ;  // unknown opcode: ignored, keyframe closed
            endcase
          end
        end
        PH_ENTRY_SCALE: begin
          res_valid         = 1'b1;
          res.record_kind   = KIND_ENTRY;
          res.count_or_time = {3'b000, held_tc};
          res.node_index    = held_node;
          res.aux_word      = w;
          phase_next        = (axis_mask != '0) ? PH_AXIS : PH_INSTR;
        end
        PH_AXIS: begin
          axis_mask_next           = axis_mask;
          axis_mask_next[axis_bit] = 1'b0;
          res_valid         = 1'b1;
          res.record_kind   = KIND_AXIS;
          res.count_or_time = {3'b000, held_tc};
          res.node_index    = held_node;
          res.component     = COMP_LAST - axis_bit;
          res.signed_value  = w;
          if (axis_mask_next == '0) phase_next = PH_INSTR;
        end
        PH_LOOP_END: begin
          res_valid         = 1'b1;
          res.record_kind   = KIND_LOOP_END;
          res.count_or_time = {3'b000, held_tc};
          res.aux_word      = w;
          phase_next        = PH_INSTR;
        end
        PH_TEXTURE: begin
          if (tex_cnt == 2'd0) begin
            tex_words_next = {16'h0000, w};
            tex_cnt_next   = 2'd1;
          end else if (tex_cnt == 2'd1) begin
            tex_words_next = {w, tex_words[15:0]};
            tex_cnt_next   = 2'd2;
          end else begin
            res_valid         = 1'b1;
            res.record_kind   = KIND_TEXTURE;
            res.count_or_time = {3'b000, held_tc};
            res.texture_rect  = {tex_words[7:0], tex_words[15:8],
                                 tex_words[23:16], tex_words[31:24],
                                 w[7:0], w[15:8]};
            tex_cnt_next      = '0;
            phase_next        = PH_INSTR;
          end
        end
        PH_SOUND: begin
          res_valid         = 1'b1;
          res.record_kind   = KIND_SOUND;
          res.count_or_time = {3'b000, held_tc};
          res.aux_word      = w;
          phase_next        = PH_INSTR;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count   <= 7'd1;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      phase        <= PH_HEADER;
      scale_flag   <= 1'b0;
      bone_counter <= 7'd1;
      comp_cnt     <= '0;
      axis_mask    <= '0;
      in_keyframe  <= 1'b0;
      held_tc      <= '0;
      tex_words    <= '0;
      tex_cnt      <= '0;
      held_node    <= '0;
    end else begin
      if (cfg_wr_en) bone_count <= cfg_wr_data;
      if (in_ready) begin
        s1_valid <= in_valid;
        s1_data  <= in_data;
      end
      if (s2_free) begin
        out_valid <= s1_valid && res_valid;
        out_data  <= res;
      end
      if (s1_go) begin
        phase        <= phase_next;
        scale_flag   <= scale_flag_next;
        bone_counter <= bone_counter_next;
        comp_cnt     <= comp_cnt_next;
        axis_mask    <= axis_mask_next;
        in_keyframe  <= in_keyframe_next;
        held_tc      <= held_tc_next;
        tex_words    <= tex_words_next;
        tex_cnt      <= tex_cnt_next;
        held_node    <= held_node_next;
      end
    end
  end

endmodule

>>> design/awsp_checker.sv
// Port-level checks for the animation word stream parser, bound to the core.
// Depends on awsp_pkg and animation_word_stream_parser_core.
module awsp_port_props
  import awsp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input awsp_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("record valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled record changed or dropped");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.record_kind <= KIND_ERROR)
    else $error("record kind out of range");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.record_kind == KIND_ERROR || out_data.record_kind == KIND_END)
    |-> out_data.count_or_time == '0 && out_data.aux_word == '0 &&
        out_data.texture_rect == '0 && out_data.signed_value == '0)
    else $error("error/end record carries payload");

  a_scale_header_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.record_kind != KIND_HEADER |-> !out_data.scale_present)
    else $error("scale flag outside header record");

endmodule

bind animation_word_stream_parser_core awsp_port_props u_awsp_checker (.*);

>>> tb/awsp_checker.sv
// Checker for the animation word stream parser: watches both channels and the
// bone_count write port, predicts each record and compares it. Uses awsp_pkg.
`timescale 1ns / 100ps

module awsp_checker
  import awsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  awsp_in_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  awsp_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  output int         fails,
  output int         pending,
  output int         checked
);

  localparam int BONE_LIMIT = 64;
  localparam int PRINT_LIMIT = 25;

  typedef enum logic [2:0] {
    ST_HEADER, ST_POSE, ST_INSTR, ST_ENTRY_SCALE, ST_AXIS, ST_LOOP_END, ST_TEXTURE,
    ST_SOUND
  } parse_state_t;

  // predicted parser state
  parse_state_t phase;
  logic [6:0]   bone_count;
  logic         scale_on;
  logic [6:0]   bone_idx;
  logic [3:0]   comp_idx;
  logic [8:0]   axes_left;
  logic         in_kf;
  logic [11:0]  tc_held;
  logic [5:0]   node_held;
  logic [15:0]  tex_w0;
  logic [15:0]  tex_w1;
  logic [1:0]   tex_n;

  awsp_out_t pending_records[$];

  initial begin
    fails = 0;
    checked = 0;
    pending = 0;
  end

  function automatic void restart_parse();
    phase = ST_HEADER;
    bone_idx = 7'd1;
    comp_idx = 4'd0;
    axes_left = '0;
    in_kf = 1'b0;
    tex_n = 2'd0;
  endfunction

  // Advance the predicted parser by one word; returns 1 when a record results.
  function automatic bit parse_word(input awsp_in_t item, output awsp_out_t rec);
    logic [15:0] w;
    logic [11:0] tc;
    logic [6:0]  nb;
    int          hi;
    w = item.data_word;
    tc = w[11:0];
    nb = (bone_count > 7'(BONE_LIMIT)) ? 7'(BONE_LIMIT) : bone_count;
    rec = '0;
    // stream end anywhere but on the terminator aborts the animation
    if (item.stream_end && !(phase == ST_INSTR && w == 16'h0000)) begin
      rec.record_kind = KIND_ERROR;
      restart_parse();
      return 1'b1;
    end
    case (phase)
      ST_HEADER: begin
        scale_on = w[15];
        rec.record_kind = KIND_HEADER;
        rec.count_or_time = w[14:0];
        rec.scale_present = w[15];
        bone_idx = 7'd1;
        comp_idx = w[15] ? 4'd0 : COMP_ROT_X;
        in_kf = 1'b0;
        phase = (nb > 7'd1) ? ST_POSE : ST_INSTR;
        return 1'b1;
      end
      ST_POSE: begin
        rec.record_kind = KIND_POSE;
        rec.node_index = bone_idx[5:0];
        rec.component = comp_idx;
        rec.signed_value = w;
        if (comp_idx >= COMP_LAST) begin
          bone_idx = bone_idx + 7'd1;
          comp_idx = scale_on ? 4'd0 : COMP_ROT_X;
          if (bone_idx >= nb) phase = ST_INSTR;
        end else begin
          comp_idx = comp_idx + 4'd1;
        end
        return 1'b1;
      end
      ST_INSTR: begin
        if (w == 16'h0000) begin
          rec.record_kind = KIND_END;
          restart_parse();
          return 1'b1;
        end
        if (in_kf && w[15]) begin
          node_held = w[5:0];
          axes_left = w[14:6];
          phase = ST_ENTRY_SCALE;
          return 1'b0;
        end
        in_kf = 1'b0;
        case (w[15:12])
          OP_KEYFRAME: begin
            tc_held = tc;
            in_kf = 1'b1;
            rec.record_kind = KIND_KEYFR;
            rec.count_or_time = 15'(tc);
            return 1'b1;
          end
          OP_LOOP_START: begin
            rec.record_kind = KIND_LOOP_ST;
            rec.count_or_time = 15'(w[7:0]);
            return 1'b1;
          end
          OP_LOOP_END: begin
            tc_held = tc;
            phase = ST_LOOP_END;
          end
          OP_TEXTURE: begin
            tc_held = tc;
            tex_n = 2'd0;
            tex_w0 = '0;
            tex_w1 = '0;
            phase = ST_TEXTURE;
          end
          OP_SOUND: begin
            tc_held = tc;
            phase = ST_SOUND;
          end
          default: ;
        endcase
        return 1'b0;
      end
      ST_ENTRY_SCALE: begin
        rec.record_kind = KIND_ENTRY;
        rec.count_or_time = 15'(tc_held);
        rec.node_index = node_held;
        rec.aux_word = w;
        phase = (axes_left != '0) ? ST_AXIS : ST_INSTR;
        return 1'b1;
      end
      ST_AXIS: begin
        // mask bit 8 is axis 0, taken first
        hi = 8;
        while (hi > 0 && !axes_left[hi]) hi--;
        axes_left[hi] = 1'b0;
        rec.record_kind = KIND_AXIS;
        rec.count_or_time = 15'(tc_held);
        rec.node_index = node_held;
        rec.component = 4'(8 - hi);
        rec.signed_value = w;
        if (axes_left == '0) phase = ST_INSTR;
        return 1'b1;
      end
      ST_LOOP_END: begin
        rec.record_kind = KIND_LOOP_END;
        rec.count_or_time = 15'(tc_held);
        rec.aux_word = w;
        phase = ST_INSTR;
        return 1'b1;
      end
      ST_TEXTURE: begin
        if (tex_n == 2'd0) begin
          tex_w0 = w;
          tex_n = 2'd1;
          return 1'b0;
        end
        if (tex_n == 2'd1) begin
          tex_w1 = w;
          tex_n = 2'd2;
          return 1'b0;
        end
        // bytes in stream order, first byte on top
        rec.record_kind = KIND_TEXTURE;
        rec.count_or_time = 15'(tc_held);
        rec.texture_rect = {tex_w0[7:0], tex_w0[15:8], tex_w1[7:0], tex_w1[15:8],
                            w[7:0], w[15:8]};
        tex_n = 2'd0;
        phase = ST_INSTR;
        return 1'b1;
      end
      ST_SOUND: begin
        rec.record_kind = KIND_SOUND;
        rec.count_or_time = 15'(tc_held);
        rec.aux_word = w;
        phase = ST_INSTR;
        return 1'b1;
      end
      default: begin
        restart_parse();
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report(input string msg);
    if (fails < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    fails++;
  endtask

  task automatic compare_record(input awsp_out_t got, input awsp_out_t want);
    string tag;
    tag = $sformatf("record %0d (kind %0d)", checked, want.record_kind);
    if (got.record_kind !== want.record_kind)
      report($sformatf("%s record_kind %0h", tag, got.record_kind));
    if (got.count_or_time !== want.count_or_time)
      report($sformatf("%s count_or_time %0h, want %0h", tag, got.count_or_time,
                       want.count_or_time));
    if (got.scale_present !== want.scale_present)
      report($sformatf("%s scale_present %0b", tag, got.scale_present));
    if (got.node_index !== want.node_index)
      report($sformatf("%s node_index %0d, want %0d", tag, got.node_index, want.node_index));
    if (got.component !== want.component)
      report($sformatf("%s component %0d, want %0d", tag, got.component, want.component));
    if (got.signed_value !== want.signed_value)
      report($sformatf("%s signed_value %0h, want %0h", tag, got.signed_value,
                       want.signed_value));
    if (got.aux_word !== want.aux_word)
      report($sformatf("%s aux_word %0h, want %0h", tag, got.aux_word, want.aux_word));
    if (got.texture_rect !== want.texture_rect)
      report($sformatf("%s texture_rect %0h, want %0h", tag, got.texture_rect,
                       want.texture_rect));
  endtask

  always @(posedge clk) begin : watch
    awsp_out_t rec;
    awsp_out_t want;
    if (rst) begin
      bone_count = 7'd1;
      scale_on = 1'b0;
      tc_held = '0;
      node_held = '0;
      tex_w0 = '0;
      tex_w1 = '0;
      restart_parse();
      pending_records.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) bone_count = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (parse_word(in_data, rec)) pending_records.insert(pending_records.size(), rec);
      end
      if (out_valid && out_ready) begin
        if (pending_records.size() == 0) begin
          report($sformatf("unexpected record, kind %0d", out_data.record_kind));
        end else begin
          want = pending_records.pop_front();
          compare_record(out_data, want);
          checked++;
        end
      end
      pending <= pending_records.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the parser testbench: clock, reset, word stimulus, receiver stalls and verdict.
// Depends on awsp_pkg, animation_word_stream_parser_core and awsp_checker.
`timescale 1ns / 100ps

module tb_top;
  import awsp_pkg::*;

  // instruction types the parser ignores
  localparam logic [3:0] OP_UNKNOWN_LO = 4'd5;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
  localparam int         LONG_HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  awsp_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  awsp_out_t  out_data;
  logic       cfg_wr_en;
  logic [6:0] cfg_wr_data;

  int chk_fails;
  int chk_pending;
  int chk_checked;

  int         words_sent;
  int         err_rate;      // per mille chance of a premature stream end
  bit         aborted;
  bit         tx_idle;
  bit         rx_idle;
  bit         long_hold;
  bit         hold_done;
  logic [6:0] bones_now;
  logic [6:0] mid_bones;

  // {stream_end, word}
  logic [16:0] opening_words[$] = {
    {1'b0, 16'hFFFF},                         // header: scale set, max frame count
    {1'b0, OP_KEYFRAME, 12'hFFF},
    {1'b0, 1'b1, 9'h1FF, 6'h3F},              // entry, all axes, node 63
    {1'b0, 16'h8000},
    {1'b0, 16'h7FFF}, {1'b0, 16'h8000}, {1'b0, 16'h0000},
    {1'b0, 16'hFFFF}, {1'b0, 16'h0001}, {1'b0, 16'hFFFE},
    {1'b0, 16'h1234}, {1'b0, 16'hEDCB}, {1'b0, 16'h5555},
    {1'b0, 1'b1, 9'h000, 6'h00},              // entry with no axes
    {1'b0, 16'hFFFF},
    {1'b0, OP_LOOP_START, 12'hFFF},
    {1'b0, OP_LOOP_END, 12'h001}, {1'b0, 16'hFFFF},
    {1'b0, OP_TEXTURE, 12'h800},
    {1'b0, 16'h0102}, {1'b0, 16'hFEFD}, {1'b0, 16'hAA55},
    {1'b0, OP_SOUND, 12'hFFF}, {1'b0, 16'h7F80},
    {1'b0, OP_UNKNOWN_HI, 12'hFFF},           // bit 15 outside a keyframe
    {1'b0, OP_UNKNOWN_LO, 12'h000},
    {1'b1, 16'h0000},                         // terminator on the last word
    {1'b1, 16'h0000},                         // buffer ends on a header
    {1'b0, 16'h0000},
    {1'b1, OP_LOOP_START, 12'h000}            // buffer ends mid-stream
  };

  animation_word_stream_parser_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  awsp_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fails      (chk_fails),
    .pending    (chk_pending),
    .checked    (chk_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(input logic [15:0] w, input logic last);
    if (tx_idle && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {w, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // one word of an animation; a premature stream end drops the rest of it
  task automatic put(input logic [15:0] w);
    logic last;
    if (aborted) return;
    last = (err_rate != 0) && ($urandom_range(0, 999) < err_rate);
    send_word(w, last);
    if (last) aborted = 1'b1;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bones(input logic [6:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bones_now = v;
  endtask

  task automatic gen_animation(input bit no_scale, input int max_instr);
    logic       scale;
    logic [8:0] mask;
    int         nb;
    aborted = 1'b0;
    scale = no_scale ? 1'b0 : 1'($urandom_range(0, 1));
    put({scale, 15'($urandom_range(0, 32767))});
    nb = (bones_now > 7'd64) ? 64 : int'(bones_now);
    if (nb > 1) repeat ((nb - 1) * (scale ? 9 : 6)) put(rand_word());
    repeat ($urandom_range(0, max_instr)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          put({OP_KEYFRAME, 12'($urandom_range(1, 4095))});
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
              0: mask = '0;
              1: mask = '1;
              default: mask = 9'($urandom_range(0, 511));
            endcase
            put({1'b1, mask, 6'($urandom_range(0, 63))});
            put(rand_word());
            repeat ($countones(mask)) put(rand_word());
          end
        end
        4: put({OP_LOOP_START, 12'($urandom_range(0, 4095))});
        5: begin
          put({OP_LOOP_END, 12'($urandom_range(0, 4095))});
          put(rand_word());
        end
        6: begin
          put({OP_TEXTURE, 12'($urandom_range(0, 4095))});
          repeat (3) put(rand_word());
        end
        7: begin
          put({OP_SOUND, 12'($urandom_range(0, 4095))});
          put(rand_word());
        end
        default: put({4'($urandom_range(int'(OP_UNKNOWN_LO), int'(OP_UNKNOWN_HI))),
                      12'($urandom_range(0, 4095))});
      endcase
    end
    if (!aborted) send_word(16'h0000, 1'($urandom_range(0, 1)));
  endtask

  task automatic fill_words(input int quota, input int max_instr, input bit noise);
    int start;
    start = words_sent;
    while (words_sent - start < quota) begin
      // loose words drop the parser into arbitrary states
      if (noise && $urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 6)) send_word(rand_word(), $urandom_range(0, 7) == 0);
      gen_animation(1'b0, max_instr);
    end
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin : receiver
    int held;
    out_ready = 1'b0;
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_idle && $urandom_range(0, 99) < 10) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #(4_000_000);
    $display("Timeout with %0d records still expected", chk_pending);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    words_sent = 0;
    err_rate = 0;
    aborted = 1'b0;
    bones_now = 7'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset bone count
    foreach (opening_words[i]) send_word(opening_words[i][15:0], opening_words[i][16]);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_bones(7'd0);
    fill_words(220, 12, 1'b0);

    // receiver holds off while words keep coming
    set_bones(7'd2);
    long_hold = 1'b1;
    fill_words(300, 12, 1'b0);

    // full skeleton, one animation
    set_bones(7'd64);
    gen_animation(1'b1, 6);

    mid_bones = 7'($urandom_range(3, 9));
    set_bones(mid_bones);
    err_rate = 15;
    fill_words(350, 14, 1'b1);

    // closing stretch without idling
    set_bones(7'd1);
    err_rate = 5;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    fill_words(220, 14, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d words with bone counts 1, 0, 2, 64, %0d and 1 again;",
             words_sent, mid_bones);
    $display("%0d records compared, %0d mismatches", chk_checked, chk_fails);
    if (chk_fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
